// ===== hw/rtl/epm_pkg.sv =====
`default_nettype none

package epm_pkg;

  typedef enum logic [1:0] {
    OP_SEND    = 2'd0,
    OP_EXPIRY  = 2'd1,
    OP_REPLY   = 2'd2,
    OP_UNREACH = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ALARM_NONE    = 2'd0,
    ALARM_TIMEOUT = 2'd1,
    ALARM_OK      = 2'd2,
    ALARM_UNREACH = 2'd3
  } alarm_e;

  typedef enum logic [2:0] {
    VERDICT_NONE     = 3'd0,
    VERDICT_ACCEPT   = 3'd1,
    VERDICT_BAD_SRC  = 3'd2,
    VERDICT_BAD_DST  = 3'd3,
    VERDICT_SHORT    = 3'd4,
    VERDICT_BAD_TYPE = 3'd5,
    VERDICT_BAD_ID   = 3'd6,
    VERDICT_BAD_SEQ  = 3'd7
  } verdict_e;

  typedef enum logic [2:0] {
    REG_ECHO_IDENT     = 3'd0,
    REG_PEER_ADDR      = 3'd1,
    REG_LOCAL_ADDR     = 3'd2,
    REG_LOCAL_CHECK    = 3'd3,
    REG_IPV6_MODE      = 3'd4,
    REG_TIMEOUT_MS     = 3'd5,
    REG_UP_THRESHOLD   = 3'd6,
    REG_DOWN_THRESHOLD = 3'd7
  } cfg_reg_e;

  localparam logic [1:0] SESSION_DOWN = 2'd0;
  localparam logic [1:0] SESSION_UP   = 2'd1;

  localparam logic [7:0] ICMP_ECHO_REPLY   = 8'd0;
  localparam logic [7:0] ICMPV6_REPLY_TYPE = 8'd129;
  localparam logic [6:0] ECHO_HDR_BYTES    = 7'd8;

  localparam int unsigned LimitW     = 33;
  localparam logic [9:0]  US_PER_MS  = 10'd1000;
  localparam logic [LimitW-1:0] LIMIT_RESET = 33'd1000000;

  typedef struct packed {
    op_e         operation;
    logic [1:0]  session_state;
    logic        send_ok;
    logic [31:0] rx_src_addr;
    logic [31:0] rx_dst_addr;
    logic [3:0]  rx_header_words;
    logic [15:0] rx_length;
    logic [7:0]  rx_type;
    logic [15:0] rx_ident;
    logic [15:0] rx_seq;
    logic [31:0] rtt_us;
  } req_t;

  typedef struct packed {
    alarm_e      alarm;
    logic [15:0] send_seq;
    verdict_e    reply_verdict;
    logic        late_reply;
    logic        retry_pending;
    logic        cancel_timer;
    logic [31:0] tx_count;
    logic [31:0] rx_count;
    logic [31:0] miss_count;
  } rsp_t;

  typedef struct packed {
    cfg_reg_e    index;
    logic [31:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [15:0]       echo_ident;
    logic [31:0]       peer_address;
    logic [31:0]       local_address;
    logic              local_check_enable;
    logic              ipv6_mode;
    logic [LimitW-1:0] limit_us;
    logic [7:0]        up_threshold;
    logic [7:0]        down_threshold;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/epm_stream_if.sv =====
`default_nettype none

interface epm_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/epm_cfg_regs.sv =====
`default_nettype none

module epm_cfg_regs (
  input  wire             clk_i,
  input  wire             rst_ni,
  epm_stream_if.sink      cfg_i,
  output epm_pkg::cfg_t   cfg_o
);
  import epm_pkg::*;

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.echo_ident         <= '0;
      cfg_q.peer_address       <= '0;
      cfg_q.local_address      <= '0;
      cfg_q.local_check_enable <= 1'b0;
      cfg_q.ipv6_mode          <= 1'b0;
      cfg_q.limit_us           <= LIMIT_RESET;
      cfg_q.up_threshold       <= '0;
      cfg_q.down_threshold     <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.payload.index)
        REG_ECHO_IDENT:     cfg_q.echo_ident         <= cfg_i.payload.data[15:0];
        REG_PEER_ADDR:      cfg_q.peer_address       <= cfg_i.payload.data;
        REG_LOCAL_ADDR:     cfg_q.local_address      <= cfg_i.payload.data;
        REG_LOCAL_CHECK:    cfg_q.local_check_enable <= cfg_i.payload.data[0];
        REG_IPV6_MODE:      cfg_q.ipv6_mode          <= cfg_i.payload.data[0];
        REG_TIMEOUT_MS:     cfg_q.limit_us           <=
            LimitW'(cfg_i.payload.data[22:0]) * LimitW'(US_PER_MS);
        REG_UP_THRESHOLD:   cfg_q.up_threshold       <= cfg_i.payload.data[7:0];
        REG_DOWN_THRESHOLD: cfg_q.down_threshold     <= cfg_i.payload.data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/epm_reply_check.sv =====
`default_nettype none

module epm_reply_check (
  input  epm_pkg::req_t     item_i,
  input  epm_pkg::cfg_t     cfg_i,
  input  logic [15:0]       next_seq_i,
  output epm_pkg::verdict_e verdict_o
);
  import epm_pkg::*;

  logic [15:0] expected_seq;
  logic [6:0]  min_len;

  assign expected_seq = next_seq_i - 16'd1;
  assign min_len      = 7'({item_i.rx_header_words, 2'b00}) + ECHO_HDR_BYTES;

  always_comb begin
    priority if (!cfg_i.ipv6_mode && item_i.rx_src_addr != cfg_i.peer_address) begin
      verdict_o = VERDICT_BAD_SRC;
    end else if (!cfg_i.ipv6_mode && cfg_i.local_check_enable &&
                 item_i.rx_dst_addr != cfg_i.local_address) begin
      verdict_o = VERDICT_BAD_DST;
    end else if (!cfg_i.ipv6_mode && item_i.rx_length < 16'(min_len)) begin
      verdict_o = VERDICT_SHORT;
    end else if (!cfg_i.ipv6_mode && item_i.rx_type != ICMP_ECHO_REPLY) begin
      verdict_o = VERDICT_BAD_TYPE;
    end else if (cfg_i.ipv6_mode && item_i.rx_type != ICMPV6_REPLY_TYPE) begin
      verdict_o = VERDICT_BAD_TYPE;
    end else if (item_i.rx_ident != cfg_i.echo_ident) begin
      verdict_o = VERDICT_BAD_ID;
    end else if (item_i.rx_seq != expected_seq) begin
      verdict_o = VERDICT_BAD_SEQ;
    end else begin
      verdict_o = VERDICT_ACCEPT;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/epm_event_core.sv =====
`default_nettype none

module epm_event_core (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  logic              adv_i,
  input  epm_pkg::req_t     item_i,
  input  epm_pkg::cfg_t     cfg_i,
  input  epm_pkg::verdict_e verdict_i,
  output logic [15:0]       next_seq_o,
  output epm_pkg::rsp_t     rsp_o
);
  import epm_pkg::*;

  typedef struct packed {
    logic       hold;
    logic [7:0] count;
    logic       up_ip;
    logic       down_ip;
    logic       counted;
  } retry_t;

  function automatic retry_t retry_step(input logic [1:0] session,
                                        input logic [7:0] needed,
                                        input logic going_up,
                                        input retry_t cur);
    retry_t r;
    logic   skip;
    logic   flip;
    r      = cur;
    r.hold = 1'b0;
    skip   = (session == SESSION_UP && going_up) ||
             (session == SESSION_DOWN && !going_up);
    flip   = (cur.up_ip && !going_up) || (cur.down_ip && going_up);
    if (!skip) begin
      if (flip) begin
        r.count   = '0;
        r.up_ip   = going_up;
        r.down_ip = !going_up;
      end
      if (cur.counted) begin
        r.counted = 1'b0;
      end else begin
        r.counted = 1'b1;
        r.count   = r.count + 8'd1;
      end
      r.hold = r.count < needed;
    end
    return r;
  endfunction

  alarm_e      alarm_q, alarm_d;
  logic [15:0] next_seq_q, next_seq_d;
  retry_t      retry_q, retry_d;
  logic        reply_seen_q, reply_seen_d;
  logic [31:0] tx_q, tx_d, rx_q, rx_d, miss_q, miss_d;
  retry_t      ret_dn, ret_up;
  logic        late;

  assign next_seq_o = next_seq_q;
  assign late       = {1'b0, item_i.rtt_us} > cfg_i.limit_us;

  always_comb begin
    ret_dn = retry_step(item_i.session_state, cfg_i.down_threshold, 1'b0, retry_q);
    ret_up = retry_step(item_i.session_state, cfg_i.up_threshold, 1'b1, retry_q);
  end

  always_comb begin
    alarm_d      = alarm_q;
    next_seq_d   = next_seq_q;
    retry_d      = retry_q;
    reply_seen_d = reply_seen_q;
    tx_d         = tx_q;
    rx_d         = rx_q;
    miss_d       = miss_q;
    rsp_o.send_seq      = '0;
    rsp_o.reply_verdict = VERDICT_NONE;
    rsp_o.late_reply    = 1'b0;
    rsp_o.retry_pending = 1'b0;
    rsp_o.cancel_timer  = 1'b0;

    unique case (item_i.operation)
      OP_SEND: begin
        rsp_o.send_seq  = next_seq_q;
        next_seq_d      = next_seq_q + 16'd1;
        reply_seen_d    = 1'b0;
        retry_d.counted = 1'b0;
        if (item_i.send_ok) begin
          tx_d = tx_q + 32'd1;
        end
      end
      OP_EXPIRY: begin
        if (!reply_seen_q) begin
          miss_d  = miss_q + 32'd1;
          retry_d = ret_dn;
          if (ret_dn.hold) begin
            rsp_o.retry_pending = 1'b1;
            rsp_o.cancel_timer  = 1'b1;
          end else begin
            if (alarm_q != ALARM_UNREACH) begin
              alarm_d = ALARM_TIMEOUT;
            end
            retry_d.count   = '0;
            retry_d.up_ip   = 1'b0;
            retry_d.down_ip = 1'b0;
          end
        end
      end
      OP_REPLY: begin
        rsp_o.reply_verdict = verdict_i;
        if (verdict_i == VERDICT_ACCEPT) begin
          rx_d = rx_q + 32'd1;
          if (late) begin
            rsp_o.late_reply = 1'b1;
            if (!reply_seen_q) begin
              miss_d = miss_q + 32'd1;
            end
            retry_d = ret_dn;
            if (ret_dn.hold) begin
              rsp_o.retry_pending = 1'b1;
              rsp_o.cancel_timer  = 1'b1;
            end else if (alarm_q != ALARM_UNREACH) begin
              alarm_d = ALARM_TIMEOUT;
            end
          end else begin
            retry_d = ret_up;
            if (ret_up.hold) begin
              rsp_o.retry_pending = 1'b1;
              rsp_o.cancel_timer  = 1'b1;
            end else begin
              alarm_d             = ALARM_OK;
              reply_seen_d        = 1'b1;
              retry_d.count       = '0;
              retry_d.up_ip       = 1'b0;
              retry_d.down_ip     = 1'b0;
              rsp_o.cancel_timer  = 1'b1;
            end
          end
        end
      end
      OP_UNREACH: begin
        if (alarm_q != ALARM_TIMEOUT) begin
          alarm_d = ALARM_UNREACH;
        end
      end
      default: ;
    endcase

    retry_d.hold     = 1'b0;
    rsp_o.alarm      = alarm_d;
    rsp_o.tx_count   = tx_d;
    rsp_o.rx_count   = rx_d;
    rsp_o.miss_count = miss_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_q      <= ALARM_NONE;
      next_seq_q   <= '0;
      retry_q      <= '0;
      reply_seen_q <= 1'b0;
      tx_q         <= '0;
      rx_q         <= '0;
      miss_q       <= '0;
    end else if (adv_i) begin
      alarm_q      <= alarm_d;
      next_seq_q   <= next_seq_d;
      retry_q      <= retry_d;
      reply_seen_q <= reply_seen_d;
      tx_q         <= tx_d;
      rx_q         <= rx_d;
      miss_q       <= miss_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/echo_path_liveness_monitor.sv =====
// Echo path liveness monitor.
// Channels: req_i carries one event request (send, timer expiry, reply,
// next hop unreachable) with the reply header fields and round trip time;
// rsp_o returns exactly one result per request (alarm, sequence used,
// reply verdict, retry and cancel flags, and the three wrapping counters);
// cfg_i writes one register per handshake and is always ready.
// Path: a request accepted on req_i sits in the input register, and its result
// is then loaded into the output register, from which it is offered on rsp_o;
// the load waits while the output register holds a result rsp_o has not taken.
// Throughput: one request per cycle while rsp_o is not held off, set by the
// single pass of reply checks and counter updates between the two registers.
// Stall: while rsp_o is held off, the output register keeps its result, one
// further request waits in the input register, and req_i.ready falls.
// Reset: alarm, sequence, retry state and counters clear; the round trip
// limit returns to 1000 ms and all other registers to zero.
`default_nettype none

module echo_path_liveness_monitor (
  input  wire          clk_i,
  input  wire          rst_ni,
  epm_stream_if.sink   req_i,
  epm_stream_if.source rsp_o,
  epm_stream_if.sink   cfg_i
);
  import epm_pkg::*;

  cfg_t     cfg;
  verdict_e verdict;
  rsp_t     rsp_d;
  logic     advance;
  logic     s1_valid_q;
  req_t     s1_item_q;
  logic     rsp_valid_q;
  rsp_t     rsp_item_q;
  logic [15:0] next_seq;

  epm_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  epm_reply_check u_check (
    .item_i     (s1_item_q),
    .cfg_i      (cfg),
    .next_seq_i (next_seq),
    .verdict_o  (verdict)
  );

  epm_event_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (advance),
    .item_i     (s1_item_q),
    .cfg_i      (cfg),
    .verdict_i  (verdict),
    .next_seq_o (next_seq),
    .rsp_o      (rsp_d)
  );

  assign advance       = s1_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready   = !s1_valid_q || advance;
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (advance) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_item_q <= req_i.payload;
    end
    if (advance) begin
      rsp_item_q <= rsp_d;
    end
  end

`ifndef SYNTHESIS
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> s1_valid_q)
    else $error("accepted request not held in input register");

  a_wait_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> (s1_valid_q && $stable(s1_item_q)))
    else $error("waiting request lost or changed");

  a_advance_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> rsp_valid_q)
    else $error("advanced request produced no result");

  a_late_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_item_q.late_reply) |->
      (rsp_item_q.reply_verdict == VERDICT_ACCEPT))
    else $error("late flag on a reply that was not accepted");

  a_pending_cancels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_item_q.retry_pending) |-> rsp_item_q.cancel_timer)
    else $error("held alarm change without timer cancel");
`endif

endmodule

`default_nettype wire

// ===== test/echo_path_liveness_monitor_test.sv =====
module echo_path_liveness_monitor_test;
  timeunit 1ns;
  timeprecision 1ps;

  import epm_pkg::*;

  localparam logic [1:0] SESSION_OTHER = 2'd2;
  localparam logic [1:0] SESSION_SPARE = 2'd3;
  localparam int         SHOWN_FAULTS  = 40;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t want;
  } probe_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  epm_stream_if #(.payload_t(req_t))    req_if ();
  epm_stream_if #(.payload_t(rsp_t))    rsp_if ();
  epm_stream_if #(.payload_t(cfg_wr_t)) cfg_if ();

  echo_path_liveness_monitor dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  // register copies
  logic [15:0] cfg_ident          = '0;
  logic [31:0] cfg_peer           = '0;
  logic [31:0] cfg_local          = '0;
  logic        cfg_local_check    = 1'b0;
  logic        cfg_ipv6           = 1'b0;
  logic [22:0] cfg_timeout_ms     = 23'd1000;
  logic [7:0]  cfg_up_threshold   = '0;
  logic [7:0]  cfg_down_threshold = '0;

  // path state
  alarm_e      path_alarm    = ALARM_NONE;
  logic [15:0] path_next_seq = '0;
  logic [7:0]  path_retries  = '0;
  logic        path_rising   = 1'b0;
  logic        path_falling  = 1'b0;
  logic        path_counted  = 1'b0;
  logic        path_answered = 1'b0;
  logic [31:0] path_tx       = '0;
  logic [31:0] path_rx       = '0;
  logic [31:0] path_miss     = '0;
  logic        path_cancel   = 1'b0;

  rsp_t        status_due [$];
  probe_t      probes [$];
  logic [31:0] setting [8];

  bit pace = 1'b1;
  int faults = 0;
  int requests = 0;
  int writes = 0;
  int accepted = 0;
  int late = 0;
  int held = 0;
  int stall = 0;
  rsp_t want;

  function automatic logic retry_holds(input logic [1:0] session, input logic [7:0] needed,
                                       input logic going_up);
    if ((session == SESSION_UP && going_up) || (session == SESSION_DOWN && !going_up))
      return 1'b0;
    if ((path_rising && !going_up) || (path_falling && going_up)) begin
      path_retries = '0;
      path_rising  = going_up;
      path_falling = !going_up;
    end
    if (path_counted) begin
      path_counted = 1'b0;
    end else begin
      path_counted = 1'b1;
      path_retries = path_retries + 8'd1;
    end
    if (path_retries < needed) begin
      path_cancel = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void clear_retries();
    path_retries = '0;
    path_rising  = 1'b0;
    path_falling = 1'b0;
  endfunction

  function automatic verdict_e screen_reply(input req_t r);
    if (!cfg_ipv6) begin
      if (r.rx_src_addr != cfg_peer) return VERDICT_BAD_SRC;
      if (cfg_local_check && r.rx_dst_addr != cfg_local) return VERDICT_BAD_DST;
      if (int'(r.rx_length) < int'(r.rx_header_words) * 4 + 8) return VERDICT_SHORT;
      if (r.rx_type != ICMP_ECHO_REPLY) return VERDICT_BAD_TYPE;
    end else if (r.rx_type != ICMPV6_REPLY_TYPE) begin
      return VERDICT_BAD_TYPE;
    end
    if (r.rx_ident != cfg_ident) return VERDICT_BAD_ID;
    if (r.rx_seq != path_next_seq - 16'd1) return VERDICT_BAD_SEQ;
    return VERDICT_ACCEPT;
  endfunction

  function automatic rsp_t track_event(input req_t r);
    rsp_t        o;
    logic [63:0] limit;
    o = '0;
    path_cancel = 1'b0;
    limit = 64'(cfg_timeout_ms) * 64'd1000;
    case (r.operation)
      OP_SEND: begin
        o.send_seq    = path_next_seq;
        path_next_seq = path_next_seq + 16'd1;
        path_answered = 1'b0;
        if (r.send_ok) path_tx = path_tx + 32'd1;
        path_counted  = 1'b0;
      end
      OP_EXPIRY: begin
        if (!path_answered) begin
          path_miss = path_miss + 32'd1;
          if (retry_holds(r.session_state, cfg_down_threshold, 1'b0)) begin
            o.retry_pending = 1'b1;
          end else begin
            if (path_alarm != ALARM_UNREACH) path_alarm = ALARM_TIMEOUT;
            clear_retries();
          end
        end
      end
      OP_REPLY: begin
        o.reply_verdict = screen_reply(r);
        if (o.reply_verdict == VERDICT_ACCEPT) begin
          path_rx = path_rx + 32'd1;
          if (64'(r.rtt_us) > limit) begin
            o.late_reply = 1'b1;
            if (!path_answered) path_miss = path_miss + 32'd1;
            if (retry_holds(r.session_state, cfg_down_threshold, 1'b0))
              o.retry_pending = 1'b1;
            else if (path_alarm != ALARM_UNREACH)
              path_alarm = ALARM_TIMEOUT;
          end else if (retry_holds(r.session_state, cfg_up_threshold, 1'b1)) begin
            o.retry_pending = 1'b1;
          end else begin
            path_alarm    = ALARM_OK;
            path_answered = 1'b1;
            clear_retries();
            path_cancel   = 1'b1;
          end
        end
      end
      default: begin
        if (path_alarm != ALARM_TIMEOUT) path_alarm = ALARM_UNREACH;
      end
    endcase
    o.alarm        = path_alarm;
    o.cancel_timer = path_cancel;
    o.tx_count     = path_tx;
    o.rx_count     = path_rx;
    o.miss_count   = path_miss;
    return o;
  endfunction

  function automatic void apply_register(input cfg_reg_e idx, input logic [31:0] d);
    case (idx)
      REG_ECHO_IDENT:     cfg_ident          = d[15:0];
      REG_PEER_ADDR:      cfg_peer           = d;
      REG_LOCAL_ADDR:     cfg_local          = d;
      REG_LOCAL_CHECK:    cfg_local_check    = d[0];
      REG_IPV6_MODE:      cfg_ipv6           = d[0];
      REG_TIMEOUT_MS:     cfg_timeout_ms     = d[22:0];
      REG_UP_THRESHOLD:   cfg_up_threshold   = d[7:0];
      REG_DOWN_THRESHOLD: cfg_down_threshold = d[7:0];
      default: ;
    endcase
  endfunction

  function automatic req_t event_of(input op_e op, input logic [1:0] session, input logic ok,
                                    input logic [31:0] src, input logic [31:0] dst,
                                    input logic [3:0] hw, input logic [15:0] len,
                                    input logic [7:0] typ, input logic [15:0] id,
                                    input logic [15:0] seq, input logic [31:0] rtt);
    req_t r;
    r.operation       = op;
    r.session_state   = session;
    r.send_ok         = ok;
    r.rx_src_addr     = src;
    r.rx_dst_addr     = dst;
    r.rx_header_words = hw;
    r.rx_length       = len;
    r.rx_type         = typ;
    r.rx_ident        = id;
    r.rx_seq          = seq;
    r.rtt_us          = rtt;
    return r;
  endfunction

  function automatic rsp_t status_of(input alarm_e a, input verdict_e v, input logic [31:0] tx,
                                     input logic [31:0] rx, input logic [31:0] miss);
    rsp_t o;
    o = '0;
    o.alarm         = a;
    o.reply_verdict = v;
    o.tx_count      = tx;
    o.rx_count      = rx;
    o.miss_count    = miss;
    return o;
  endfunction

  function automatic void add_probe(input req_t r, input bit typed, input rsp_t w);
    probe_t p;
    p.req   = r;
    p.typed = typed;
    p.want  = w;
    probes.push_back(p);
  endfunction

  function automatic req_t random_event();
    req_t        r;
    int          pick;
    int          hw;
    int          lo;
    logic [63:0] limit;
    pick = $urandom_range(0, 99);
    r.operation = (pick < 25) ? OP_SEND : (pick < 45) ? OP_EXPIRY :
                  (pick < 90) ? OP_REPLY : OP_UNREACH;
    r.session_state   = 2'($urandom_range(0, 3));
    r.send_ok         = ($urandom_range(0, 4) != 0);
    r.rx_src_addr     = $urandom;
    r.rx_dst_addr     = $urandom;
    r.rx_header_words = 4'($urandom_range(0, 15));
    r.rx_length       = 16'($urandom);
    r.rx_type         = 8'($urandom);
    r.rx_ident        = 16'($urandom);
    r.rx_seq          = 16'($urandom);
    limit = 64'(cfg_timeout_ms) * 64'd1000;
    case ($urandom_range(0, 4))
      0:       r.rtt_us = '0;
      1:       r.rtt_us = limit[31:0];
      2:       r.rtt_us = limit[31:0] + 32'd1;
      3:       r.rtt_us = $urandom_range(0, limit[31:0]);
      default: r.rtt_us = $urandom;
    endcase
    if (r.operation == OP_REPLY && $urandom_range(0, 6) != 0) begin
      hw = $urandom_range(0, 15);
      lo = hw * 4 + 8;
      r.rx_header_words = 4'(hw);
      r.rx_length = ($urandom_range(0, 3) == 0) ? 16'(lo) : 16'($urandom_range(lo, 65535));
      r.rx_src_addr = cfg_peer;
      if (cfg_local_check || $urandom_range(0, 1) == 0) r.rx_dst_addr = cfg_local;
      r.rx_type  = cfg_ipv6 ? ICMPV6_REPLY_TYPE : ICMP_ECHO_REPLY;
      r.rx_ident = cfg_ident;
      r.rx_seq   = path_next_seq - 16'd1;
      if ($urandom_range(0, 6) == 0) begin
        case ($urandom_range(0, 5))
          0:       r.rx_src_addr = $urandom;
          1:       r.rx_dst_addr = $urandom;
          2:       r.rx_length   = 16'($urandom_range(0, lo));
          3:       r.rx_type     = 8'($urandom);
          4:       r.rx_ident    = 16'($urandom);
          default: r.rx_seq      = 16'($urandom);
        endcase
      end
    end
    return r;
  endfunction

  function automatic void plan_settings(input int p);
    case (p)
      0: begin
        setting[REG_ECHO_IDENT]     = $urandom_range(0, 65535);
        setting[REG_PEER_ADDR]      = $urandom;
        setting[REG_LOCAL_ADDR]     = $urandom;
        setting[REG_LOCAL_CHECK]    = 1;
        setting[REG_IPV6_MODE]      = 0;
        setting[REG_TIMEOUT_MS]     = $urandom_range(0, 3);
        setting[REG_UP_THRESHOLD]   = 2;
        setting[REG_DOWN_THRESHOLD] = 3;
      end
      1: begin
        setting[REG_ECHO_IDENT]     = $urandom_range(0, 65535);
        setting[REG_PEER_ADDR]      = $urandom;
        setting[REG_LOCAL_ADDR]     = $urandom;
        setting[REG_LOCAL_CHECK]    = $urandom_range(0, 1);
        setting[REG_IPV6_MODE]      = 1;
        setting[REG_TIMEOUT_MS]     = 4294967;
        setting[REG_UP_THRESHOLD]   = 0;
        setting[REG_DOWN_THRESHOLD] = 0;
      end
      2: begin
        setting = '{default: '0};
        setting[REG_UP_THRESHOLD]   = 255;
        setting[REG_DOWN_THRESHOLD] = 255;
      end
      3: begin
        setting[REG_ECHO_IDENT]     = 32'h0000_ffff;
        setting[REG_PEER_ADDR]      = 32'hffff_ffff;
        setting[REG_LOCAL_ADDR]     = 32'hffff_ffff;
        setting[REG_LOCAL_CHECK]    = 1;
        setting[REG_IPV6_MODE]      = 0;
        setting[REG_TIMEOUT_MS]     = $urandom_range(0, 4294967);
        setting[REG_UP_THRESHOLD]   = 1;
        setting[REG_DOWN_THRESHOLD] = 1;
      end
      default: begin
        setting[REG_ECHO_IDENT]     = $urandom_range(0, 65535);
        setting[REG_PEER_ADDR]      = $urandom;
        setting[REG_LOCAL_ADDR]     = $urandom;
        setting[REG_LOCAL_CHECK]    = $urandom_range(0, 1);
        setting[REG_IPV6_MODE]      = $urandom_range(0, 1);
        setting[REG_TIMEOUT_MS]     = $urandom_range(0, 3);
        setting[REG_UP_THRESHOLD]   = $urandom_range(0, 4);
        setting[REG_DOWN_THRESHOLD] = $urandom_range(0, 4);
      end
    endcase
  endfunction

  task automatic push_request(input req_t r);
    int   gap;
    rsp_t due;
    gap = pace ? $urandom_range(0, 17) : 0;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    do @(posedge clk_i); while (!req_if.ready);
    due = track_event(r);
    status_due.push_back(due);
    requests++;
    if (due.reply_verdict == VERDICT_ACCEPT) accepted++;
    if (due.late_reply) late++;
    if (due.retry_pending) held++;
  endtask

  task automatic settle();
    req_if.valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_settings();
    cfg_wr_t w;
    int      i;
    for (i = 0; i < 8; i++) begin
      w.index = cfg_reg_e'(i);
      w.data  = setting[i];
      cfg_if.valid   <= 1'b1;
      cfg_if.payload <= w;
      do @(posedge clk_i); while (!cfg_if.ready);
      apply_register(w.index, w.data);
      writes++;
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      faults++;
      if (faults <= SHOWN_FAULTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    if (rsp_if.valid && rsp_if.ready) begin
      if (status_due.size() == 0) begin
        faults++;
        if (faults <= SHOWN_FAULTS)
          $display("%0t: unexpected result, expected none, actual %p", $time, rsp_if.payload);
      end else begin
        want = status_due.pop_front();
        compare_field("alarm", want.alarm, rsp_if.payload.alarm);
        compare_field("send_seq", want.send_seq, rsp_if.payload.send_seq);
        compare_field("reply_verdict", want.reply_verdict, rsp_if.payload.reply_verdict);
        compare_field("late_reply", want.late_reply, rsp_if.payload.late_reply);
        compare_field("retry_pending", want.retry_pending, rsp_if.payload.retry_pending);
        compare_field("cancel_timer", want.cancel_timer, rsp_if.payload.cancel_timer);
        compare_field("tx_count", want.tx_count, rsp_if.payload.tx_count);
        compare_field("rx_count", want.rx_count, rsp_if.payload.rx_count);
        compare_field("miss_count", want.miss_count, rsp_if.payload.miss_count);
      end
      stall = pace ? $urandom_range(0, 17) : 0;
    end
    if (stall != 0) begin
      stall = stall - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  initial begin
    #20ms;
    $display("echo_path_liveness_monitor_test failed");
    $finish;
  end

  initial begin
    req_t r;
    int   i;
    int   p;

    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: peer 0, identifier 0, IPv4, no local check, 1000 ms, no retries
    add_probe(event_of(OP_SEND, SESSION_DOWN, 1'b1, '0, '0, '0, '0, '0, '0, '0, '0),
              1'b1, status_of(ALARM_NONE, VERDICT_NONE, 1, 0, 0));
    add_probe(event_of(OP_REPLY, SESSION_UP, 1'b0, 32'hffff_ffff, '0, 4'd5, 16'd28,
                       ICMP_ECHO_REPLY, '0, '0, '0),
              1'b1, status_of(ALARM_NONE, VERDICT_BAD_SRC, 1, 0, 0));
    add_probe(event_of(OP_REPLY, SESSION_UP, 1'b0, '0, 32'hffff_ffff, 4'd15, 16'd67,
                       ICMP_ECHO_REPLY, '0, '0, '0),
              1'b1, status_of(ALARM_NONE, VERDICT_SHORT, 1, 0, 0));
    add_probe(event_of(OP_REPLY, SESSION_UP, 1'b0, '0, '0, 4'd15, 16'd68, 8'hff, '0, '0, '0),
              1'b1, status_of(ALARM_NONE, VERDICT_BAD_TYPE, 1, 0, 0));
    add_probe(event_of(OP_REPLY, SESSION_UP, 1'b0, '0, '0, 4'd0, 16'hffff,
                       ICMP_ECHO_REPLY, 16'hffff, '0, '0),
              1'b1, status_of(ALARM_NONE, VERDICT_BAD_ID, 1, 0, 0));
    add_probe(event_of(OP_REPLY, SESSION_UP, 1'b0, '0, '0, 4'd0, 16'd8,
                       ICMP_ECHO_REPLY, '0, 16'hffff, '0),
              1'b1, status_of(ALARM_NONE, VERDICT_BAD_SEQ, 1, 0, 0));
    add_probe(event_of(OP_REPLY, SESSION_OTHER, 1'b0, '0, '0, 4'd5, 16'd28,
                       ICMP_ECHO_REPLY, '0, 16'd0, 32'd1000000), 1'b0, '0);
    add_probe(event_of(OP_EXPIRY, SESSION_OTHER, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0),
              1'b0, '0);
    add_probe(event_of(OP_SEND, SESSION_SPARE, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0),
              1'b0, '0);
    add_probe(event_of(OP_EXPIRY, SESSION_UP, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0),
              1'b0, '0);
    add_probe(event_of(OP_UNREACH, SESSION_DOWN, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0),
              1'b0, '0);
    add_probe(event_of(OP_SEND, SESSION_UP, 1'b1, '0, '0, '0, '0, '0, '0, '0, '0),
              1'b0, '0);
    add_probe(event_of(OP_REPLY, SESSION_DOWN, 1'b0, '0, '0, 4'd5, 16'd28,
                       ICMP_ECHO_REPLY, '0, 16'd2, 32'd1000001), 1'b0, '0);
    add_probe(event_of(OP_REPLY, SESSION_UP, 1'b0, '0, '0, 4'd5, 16'd28,
                       ICMP_ECHO_REPLY, '0, 16'd2, 32'hffff_ffff), 1'b0, '0);
    add_probe(event_of(OP_REPLY, SESSION_UP, 1'b0, '0, '0, 4'd5, 16'd28,
                       ICMP_ECHO_REPLY, '0, 16'd2, '0), 1'b0, '0);
    add_probe(event_of(OP_UNREACH, SESSION_SPARE, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0),
              1'b0, '0);
    add_probe(event_of(OP_SEND, SESSION_OTHER, 1'b1, '0, '0, '0, '0, '0, '0, '0, '0),
              1'b0, '0);
    add_probe(event_of(OP_EXPIRY, SESSION_DOWN, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0),
              1'b0, '0);
    add_probe(event_of(OP_REPLY, SESSION_SPARE, 1'b0, '0, '0, 4'd5, 16'd28,
                       ICMP_ECHO_REPLY, '0, 16'd3, 32'd999999), 1'b0, '0);
    add_probe(event_of(OP_UNREACH, SESSION_UP, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0),
              1'b0, '0);
    add_probe(event_of(OP_SEND, SESSION_DOWN, 1'b1, '0, '0, '0, '0, '0, '0, '0, '0),
              1'b0, '0);
    add_probe(event_of(OP_EXPIRY, SESSION_OTHER, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0),
              1'b0, '0);

    for (i = 0; i < probes.size(); i++) begin
      push_request(probes[i].req);
      if (probes[i].typed) status_due[status_due.size() - 1] = probes[i].want;
    end
    settle();

    // push the 8-bit retry counter past its wrap with back-to-back late replies
    setting = '{default: '0};
    write_settings();
    pace = 1'b0;
    push_request(event_of(OP_SEND, SESSION_OTHER, 1'b1, '0, '0, '0, '0, '0, '0, '0, '0));
    r = event_of(OP_REPLY, SESSION_OTHER, 1'b0, '0, '0, 4'd5, 16'd28, ICMP_ECHO_REPLY, '0,
                 path_next_seq - 16'd1, 32'd1);
    repeat (510) push_request(r);
    settle();
    setting[REG_DOWN_THRESHOLD] = 1;
    write_settings();
    push_request(r);

    for (p = 0; p < 6; p++) begin
      settle();
      plan_settings(p);
      write_settings();
      pace = (p != 4);
      repeat (70) begin
        if ($urandom_range(0, 99) == 0) settle();
        push_request(random_event());
      end
    end

    settle();
    repeat (10) @(posedge clk_i);
    $display("%0d requests over %0d register writes: reset settings, retry wrap",
             requests, writes);
    $display("and six random settings; %0d replies accepted, %0d late, %0d changes held back",
             accepted, late, held);
    if (faults == 0) begin
      $display("echo_path_liveness_monitor_test passed");
    end else begin
      $display("echo_path_liveness_monitor_test failed");
    end
    $finish;
  end

endmodule
